/* hdl/i2c_master_bit_engine_defines.svh */
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define IME_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked only out of reset
`define IME_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ime_pkg.sv */
package ime_pkg;

	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_ACK_TIMEOUT = 3'd0;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [7:0] MSB_MASK = 8'h80;

	localparam logic [2:0] DLY_NONE  = 3'd0;
	localparam logic [2:0] DLY_ONE   = 3'd1;
	localparam logic [2:0] DLY_BIT   = 3'd2;
	localparam logic [2:0] DLY_EDGE  = 3'd4;

	typedef enum logic [2:0] {
		OP_IDLE    = 3'd0,
		OP_START   = 3'd1,
		OP_STOP    = 3'd2,
		OP_WRITE   = 3'd3,
		OP_READ    = 3'd4,
		OP_ERRSTOP = 3'd5
	} op_t;

	typedef enum logic [4:0] {
		PH_S0 = 5'd0,
		PH_S1 = 5'd1,
		PH_P0 = 5'd2,
		PH_P1 = 5'd3,
		PH_W0 = 5'd4,
		PH_W1 = 5'd5,
		PH_W2 = 5'd6,
		PH_A0 = 5'd7,
		PH_A1 = 5'd8,
		PH_A2 = 5'd9,
		PH_R0 = 5'd10,
		PH_R1 = 5'd11,
		PH_K0 = 5'd12,
		PH_K1 = 5'd13
	} phase_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       op_done;
		logic [7:0] rx_byte;
		logic       ack_error;
		logic       cmd_rejected;
	} result_t;

	typedef struct packed {
		op_t         op;
		phase_t      phase;
		logic [2:0]  dly;
		logic [3:0]  bitc;
		logic [7:0]  shreg;
		logic [15:0] waitc;
		logic        ackc;
		logic        scl;
		logic        sda;
		logic        drv;
		logic        err;
		logic [7:0]  rx;
	} engine_t;

endpackage

/* hdl/ime_regs.sv */
module ime_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ime_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output logic [15:0]               ack_timeout
);

	logic [15:0] ack_timeout_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr == ime_pkg::ADDR_ACK_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ime_pkg::ACK_TIMEOUT_RST;
		end else if (wr_en) begin
			ack_timeout_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ime_pkg::ADDR_ACK_TIMEOUT) begin
			prdata = {16'd0, ack_timeout_q};
		end
	end

	assign ack_timeout = ack_timeout_q;

endmodule

/* hdl/ime_core.sv */
module ime_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ime_pkg::item_t    item,
	input  logic [15:0]       ack_timeout,
	output ime_pkg::result_t  res
);

	ime_pkg::engine_t st_q;
	ime_pkg::engine_t nx;
	logic             is_cmd;
	logic             fin;
	logic             rej;
	logic [3:0]       bc_nx;
	logic [2:0]       dly_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.op    <= ime_pkg::OP_IDLE;
			st_q.phase <= ime_pkg::PH_S0;
			st_q.dly   <= ime_pkg::DLY_NONE;
			st_q.bitc  <= 4'd0;
			st_q.shreg <= 8'd0;
			st_q.waitc <= 16'd0;
			st_q.ackc  <= 1'b0;
			st_q.scl   <= 1'b1;
			st_q.sda   <= 1'b1;
			st_q.drv   <= 1'b1;
			st_q.err   <= 1'b0;
			st_q.rx    <= 8'd0;
		end else if (fire) begin
			st_q <= nx;
		end
	end

	always_comb begin
		nx = st_q;
		fin = 1'b0;
		rej = 1'b0;
		bc_nx = st_q.bitc + 4'd1;
		dly_dec = (st_q.dly != ime_pkg::DLY_NONE) ? st_q.dly - 3'd1 : ime_pkg::DLY_NONE;
		is_cmd = (item.cmd >= ime_pkg::CMD_START) && (item.cmd <= ime_pkg::CMD_READ);
		if (is_cmd && st_q.op != ime_pkg::OP_IDLE) begin
			rej = 1'b1;
		end else if (is_cmd) begin
			nx.op = ime_pkg::op_t'(item.cmd);
			nx.bitc = 4'd0;
			nx.waitc = 16'd0;
			nx.err = 1'b0;
			nx.ackc = item.send_ack;
			nx.shreg = 8'd0;
			case (item.cmd)
				ime_pkg::CMD_START: begin
					nx.phase = ime_pkg::PH_S0;
					nx.scl = 1'b1; nx.sda = 1'b1; nx.drv = 1'b1; nx.dly = ime_pkg::DLY_EDGE;
				end
				ime_pkg::CMD_STOP: begin
					nx.phase = ime_pkg::PH_P0;
					nx.scl = 1'b0; nx.sda = 1'b0; nx.drv = 1'b1; nx.dly = ime_pkg::DLY_EDGE;
				end
				ime_pkg::CMD_WRITE: begin
					nx.phase = ime_pkg::PH_W0;
					nx.scl = 1'b0;
					nx.sda = |(item.tx_byte & ime_pkg::MSB_MASK);
					nx.drv = 1'b1;
					nx.dly = ime_pkg::DLY_BIT;
					nx.shreg = {item.tx_byte[6:0], 1'b0};
				end
				default: begin
					nx.phase = ime_pkg::PH_R0;
					nx.scl = 1'b0; nx.drv = 1'b0; nx.dly = ime_pkg::DLY_BIT;
				end
			endcase
		end else if (st_q.op != ime_pkg::OP_IDLE) begin
			if (st_q.phase == ime_pkg::PH_A2 || (dly_dec == ime_pkg::DLY_NONE &&
					st_q.phase == ime_pkg::PH_A1)) begin
				// acknowledge sample
				nx.phase = ime_pkg::PH_A2;
				nx.dly = ime_pkg::DLY_NONE;
				if (!item.sda_in) begin
					nx.scl = 1'b0;
					fin = 1'b1;
				end else if (st_q.waitc >= ack_timeout) begin
					nx.op = ime_pkg::OP_ERRSTOP;
					nx.phase = ime_pkg::PH_P0;
					nx.scl = 1'b0; nx.sda = 1'b0; nx.drv = 1'b1; nx.dly = ime_pkg::DLY_EDGE;
				end else begin
					nx.waitc = st_q.waitc + 16'd1;
				end
			end else begin
				nx.dly = dly_dec;
				if (dly_dec == ime_pkg::DLY_NONE) begin
					case (st_q.phase)
						ime_pkg::PH_S0: begin
							nx.phase = ime_pkg::PH_S1;
							nx.scl = 1'b1; nx.sda = 1'b0; nx.drv = 1'b1;
							nx.dly = ime_pkg::DLY_EDGE;
						end
						ime_pkg::PH_S1: begin
							nx.scl = 1'b0;
							fin = 1'b1;
						end
						ime_pkg::PH_P0: begin
							nx.phase = ime_pkg::PH_P1;
							nx.scl = 1'b1; nx.sda = 1'b1; nx.drv = 1'b1;
							nx.dly = ime_pkg::DLY_EDGE;
						end
						ime_pkg::PH_P1: begin
							if (st_q.op == ime_pkg::OP_ERRSTOP) begin
								nx.err = 1'b1;
							end
							fin = 1'b1;
						end
						ime_pkg::PH_W0: begin
							nx.phase = ime_pkg::PH_W1;
							nx.scl = 1'b1; nx.drv = 1'b1; nx.dly = ime_pkg::DLY_BIT;
						end
						ime_pkg::PH_W1: begin
							nx.phase = ime_pkg::PH_W2;
							nx.scl = 1'b0; nx.drv = 1'b1; nx.dly = ime_pkg::DLY_BIT;
						end
						ime_pkg::PH_W2: begin
							nx.bitc = bc_nx;
							if (bc_nx < ime_pkg::BITS_PER_BYTE) begin
								nx.phase = ime_pkg::PH_W0;
								nx.scl = 1'b0;
								nx.sda = |(st_q.shreg & ime_pkg::MSB_MASK);
								nx.drv = 1'b1;
								nx.dly = ime_pkg::DLY_BIT;
								nx.shreg = {st_q.shreg[6:0], 1'b0};
							end else begin
								nx.phase = ime_pkg::PH_A0;
								nx.scl = 1'b0; nx.sda = 1'b1; nx.drv = 1'b0;
								nx.dly = ime_pkg::DLY_ONE;
							end
						end
						ime_pkg::PH_A0: begin
							nx.phase = ime_pkg::PH_A1;
							nx.scl = 1'b1; nx.sda = 1'b1; nx.drv = 1'b0;
							nx.dly = ime_pkg::DLY_ONE;
						end
						ime_pkg::PH_R0: begin
							nx.phase = ime_pkg::PH_R1;
							nx.scl = 1'b1; nx.drv = 1'b0; nx.dly = ime_pkg::DLY_ONE;
							nx.shreg = {st_q.shreg[6:0], item.sda_in};
						end
						ime_pkg::PH_R1: begin
							nx.bitc = bc_nx;
							if (bc_nx < ime_pkg::BITS_PER_BYTE) begin
								nx.phase = ime_pkg::PH_R0;
								nx.scl = 1'b0; nx.drv = 1'b0; nx.dly = ime_pkg::DLY_BIT;
							end else begin
								nx.phase = ime_pkg::PH_K0;
								nx.scl = 1'b0; nx.sda = !st_q.ackc; nx.drv = 1'b1;
								nx.dly = ime_pkg::DLY_BIT;
							end
						end
						ime_pkg::PH_K0: begin
							nx.phase = ime_pkg::PH_K1;
							nx.scl = 1'b1; nx.drv = 1'b1; nx.dly = ime_pkg::DLY_BIT;
						end
						ime_pkg::PH_K1: begin
							nx.scl = 1'b0;
							nx.rx = st_q.shreg;
							fin = 1'b1;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			if (fin) begin
				nx.op = ime_pkg::OP_IDLE;
				nx.phase = ime_pkg::PH_S0;
				nx.dly = ime_pkg::DLY_NONE;
			end
		end
	end

	always_comb begin
		res.scl_level = nx.scl;
		res.sda_level = nx.sda;
		res.sda_drive = nx.drv;
		res.busy_res = (nx.op != ime_pkg::OP_IDLE);
		res.op_done = fin;
		res.rx_byte = nx.rx;
		res.ack_error = nx.err;
		res.cmd_rejected = rej;
	end

endmodule

/* hdl/i2c_master_bit_engine.sv */
// channel   handshake             fields
// req       req_valid/req_stall   cmd, tx_byte, send_ack, sda_in
// rsp       rsp_valid/rsp_stall   scl_level, sda_level, sda_drive, busy_res,
//                                 op_done, rx_byte, ack_error, cmd_rejected
// cfg       apb psel/penable      ack_timeout at byte address 0
//
// one word per cycle sustained while rsp_stall is low; an accepted word reaches rsp through
// the input register, then the engine step into the result register
// engine state updates in the same cycle the result is registered
// arst_n clears the engine, both valid flags and ack_timeout (250)
// rsp_stall holds the result register and backs up into req_stall
module i2c_master_bit_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [2:0]                 cmd,
	input  logic [7:0]                 tx_byte,
	input  logic                       send_ack,
	input  logic                       sda_in,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       scl_level,
	output logic                       sda_level,
	output logic                       sda_drive,
	output logic                       busy_res,
	output logic                       op_done,
	output logic [7:0]                 rx_byte,
	output logic                       ack_error,
	output logic                       cmd_rejected,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ime_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic             valid_s1;
	ime_pkg::item_t   item_s1;
	logic             valid_s2;
	ime_pkg::result_t res_s2;
	ime_pkg::result_t res_nx;
	logic             adv;
	logic             fire;
	logic [15:0]      ack_timeout;

	assign adv = !valid_s2 || !rsp_stall;
	assign fire = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.cmd <= cmd;
			item_s1.tx_byte <= tx_byte;
			item_s1.send_ack <= send_ack;
			item_s1.sda_in <= sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_nx;
		end
	end

	ime_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.ack_timeout (ack_timeout)
	);

	ime_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.ack_timeout (ack_timeout),
		.res         (res_nx)
	);

	assign rsp_valid = valid_s2;
	assign scl_level = res_s2.scl_level;
	assign sda_level = res_s2.sda_level;
	assign sda_drive = res_s2.sda_drive;
	assign busy_res = res_s2.busy_res;
	assign op_done = res_s2.op_done;
	assign rx_byte = res_s2.rx_byte;
	assign ack_error = res_s2.ack_error;
	assign cmd_rejected = res_s2.cmd_rejected;

endmodule

/* hdl/ime_checker.sv */
`include "i2c_master_bit_engine_defines.svh"

module ime_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic       scl_level,
	input logic       busy_res,
	input logic       op_done,
	input logic [7:0] rx_byte,
	input logic       ack_error,
	input logic       cmd_rejected
);

	`IME_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rx_byte) && $stable(scl_level) && $stable(op_done), "stalled result word changed")
	`IME_ASSERT_NOW(a_done_idle, rsp_valid && op_done, !busy_res && !cmd_rejected, "finished operation still busy")
	`IME_ASSERT_NOW(a_reject_busy, rsp_valid && cmd_rejected, busy_res && !op_done, "command rejected while idle")
	`IME_ASSERT_NOW(a_err_idle, rsp_valid && ack_error, !busy_res, "ack error flagged during operation")

endmodule

bind i2c_master_bit_engine ime_checker u_ime_checker (.*);
